// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helper macros used by the hash table design.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks an implication on every clock edge outside of reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/rhht_pkg.sv =====
// ----------------------------------------------------------------------------
// rhht_pkg
// Types and constants, including the hash constants, of the Robin Hood cell hash table.
// ----------------------------------------------------------------------------
package rhht_pkg;

  localparam int unsigned DefTableDepth = 1024;
  localparam int unsigned DefMaxProbe   = 32;
  localparam int unsigned SlotW         = 10;
  localparam int unsigned OccW          = 11;
  localparam int unsigned PlW           = 6;

  localparam logic [31:0] CellSizeReset = 32'h3F80_0000;
  localparam logic [31:0] UsedFlag      = 32'h8000_0000;
  localparam logic [31:0] TombWord      = 32'h0000_0001;
  localparam logic [31:0] Xp2           = 32'd2246822519;
  localparam logic [31:0] Xp3           = 32'd3266489917;
  localparam logic [31:0] Xp4           = 32'd668265263;
  localparam logic [31:0] Xp5           = 32'd374761393;
  localparam logic [31:0] Mm1           = 32'h85eb_ca6b;
  localparam logic [31:0] Mm2           = 32'hc2b2_ae35;

  typedef enum logic [1:0] {
    CmdLookup = 2'd0,
    CmdInsert = 2'd1,
    CmdErase  = 2'd2,
    CmdNone   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    StOk     = 2'd0,
    StAbsent = 2'd1,
    StFull   = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] cell_x;
    logic [31:0] cell_y;
    logic [31:0] cell_z;
    logic [31:0] store_value;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] found_value;
    logic [9:0]  slot_index;
    logic [10:0] occupancy;
  } rsp_t;

endpackage

// ===== design/robin_hood_cell_hash_table.sv =====
// ----------------------------------------------------------------------------
// robin_hood_cell_hash_table
// Open-addressed Robin Hood hash table keyed by signed 3D cell coordinates.
// ----------------------------------------------------------------------------
// One operation is handled at a time. The two hash chains run on one
// shared 32x32 multiplier (eight avalanche rounds of three steps each),
// then each probe uses the single slot memory twice (read, then compare
// and write back). An operation probes at most MAX_PROBE slots, and the
// receiver may stall the response. An insert that runs out of probes undoes
// its swaps from a small journal. The table depth is fixed by the package
// at 1024 slots. After reset a clearing pass empties the slots before the
// first transaction is taken.
`include "assert_macros.svh"
module robin_hood_cell_hash_table #(
  parameter int unsigned MAX_PROBE   = rhht_pkg::DefMaxProbe
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [31:0]    cfg_data_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  rhht_pkg::req_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output rhht_pkg::rsp_t out_data_o
);
  import rhht_pkg::*;

  localparam int unsigned TABLE_DEPTH = DefTableDepth;
  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned JW = (MAX_PROBE > 1) ? $clog2(MAX_PROBE) : 1;
  localparam int unsigned PW = $clog2(MAX_PROBE + 1);

  typedef enum logic [7:0] {
    SClear = 8'b0000_0001,
    SIdle  = 8'b0000_0010,
    SHash  = 8'b0000_0100,
    SRead  = 8'b0000_1000,
    SEval  = 8'b0001_0000,
    SUndoR = 8'b0010_0000,
    SUndoW = 8'b0100_0000,
    SOut   = 8'b1000_0000
  } state_e;

  // Slot memory: control word, value and probe length in one entry.
  typedef struct packed {
    logic [31:0]   ctrl;
    logic [31:0]   val;
    logic [PlW-1:0] pl;
  } slot_t;

  slot_t mem_q [TABLE_DEPTH];
  slot_t rd_q;
  logic  mem_we;
  logic [AW-1:0] mem_addr;
  slot_t mem_wdata;

  // Undo journal: slot and old content of every probed entry.
  logic [AW-1:0] jslot_q [MAX_PROBE];
  slot_t         jdata_q [MAX_PROBE];
  logic [JW-1:0] jw_idx, jr_idx;
  logic [AW-1:0] jr_slot_q;
  slot_t         jr_data_q;

  state_e state_q, state_d;
  logic [31:0] grid_scale_q;
  req_t  req_q;
  logic [AW:0]  clr_q, clr_d;
  logic [4:0]   hstep_q, hstep_d;
  logic [31:0]  hx_q, hx_d, hm_q, hm_d;
  logic [AW-1:0] home_q, home_d, slot_q, slot_d, where_q, where_d;
  logic [31:0]  cw_q, cw_d, cv_q, cv_d;
  logic [PlW-1:0] pl_q, pl_d;
  logic         have_q, have_d;
  logic [PW-1:0] n_q, n_d;
  logic [OccW-1:0] occ_q, occ_d;
  rsp_t rsp_q, rsp_d;

  // Hash sequencer. Each round is three steps. Steps 0..11 compute the
  // xxHash chain (4 rounds), 12..23 the Murmur chain, sharing one multiplier.
  logic [31:0] mul_a, mul_b, mul_p, hword;
  logic [1:0]  rnd;
  logic [1:0]  sub;
  logic        is_mm;
  logic [4:0]  hs;

  always_comb begin
    is_mm = (hstep_q >= 5'd12);
    hs    = is_mm ? hstep_q - 5'd12 : hstep_q;
    if (hs >= 5'd9) begin
      rnd = 2'd3;
      sub = 2'(hs - 5'd9);
    end else if (hs >= 5'd6) begin
      rnd = 2'd2;
      sub = 2'(hs - 5'd6);
    end else if (hs >= 5'd3) begin
      rnd = 2'd1;
      sub = 2'(hs - 5'd3);
    end else begin
      rnd = 2'd0;
      sub = hs[1:0];
    end
    unique case (rnd)
      2'd0:    hword = req_q.cell_z;
      2'd1:    hword = req_q.cell_y;
      2'd2:    hword = req_q.cell_x;
      default: hword = grid_scale_q;
    endcase
  end

  always_comb begin
    logic [31:0] h, src;
    src = is_mm ? hm_q : hx_q;
    h = '0;
    mul_a = 32'd0;
    mul_b = 32'd0;
    if (!is_mm) begin
      unique case (sub)
        2'd0: begin
          h = ((rnd == 2'd0) ? hword : hword + src) + Xp5;
          mul_a = {h[14:0], h[31:15]};
          mul_b = Xp4;
        end
        2'd1: begin
          mul_a = src ^ (src >> 15);
          mul_b = Xp2;
        end
        default: begin
          mul_a = src ^ (src >> 13);
          mul_b = Xp3;
        end
      endcase
    end else begin
      unique case (sub)
        2'd0: begin
          h = (rnd == 2'd0) ? hword : hword + src;
          mul_a = h ^ (h >> 16);
          mul_b = Mm1;
        end
        default: begin
          mul_a = src ^ (src >> 13);
          mul_b = Mm2;
        end
      endcase
    end
    mul_p = mul_a * mul_b;
  end

  // Murmur rounds use two multiplies; the third step applies the tail shift.
  always_comb begin
    hx_d = hx_q;
    hm_d = hm_q;
    if (state_q == SHash) begin
      if (!is_mm) begin
        if (sub == 2'd2) hx_d = mul_p ^ (mul_p >> 16);
        else             hx_d = mul_p;
      end else begin
        unique case (sub)
          2'd0:    hm_d = mul_p;
          2'd1:    hm_d = mul_p;
          default: hm_d = hm_q ^ (hm_q >> 16);
        endcase
      end
    end
  end

  // Probe logic.
  logic c_used, c_match, take, swap;
  always_comb begin
    c_used  = rd_q.ctrl[31];
    c_match = (rd_q.ctrl == cw_q);
    take    = !c_used || c_match;
    swap    = c_used && !c_match && (rd_q.pl < pl_q);
  end

  function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] s);
    logic [AW:0] t;
    t = {1'b0, s} + 1'b1;
    return (t >= (AW+1)'(TABLE_DEPTH)) ? '0 : t[AW-1:0];
  endfunction

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    hstep_d = hstep_q;
    home_d  = home_q;
    slot_d  = slot_q;
    where_d = where_q;
    cw_d    = cw_q;
    cv_d    = cv_q;
    pl_d    = pl_q;
    have_d  = have_q;
    n_d     = n_q;
    occ_d   = occ_q;
    rsp_d   = rsp_q;
    mem_we  = 1'b0;
    mem_addr = slot_q;
    mem_wdata = '{ctrl: cw_q, val: cv_q, pl: pl_q};
    jw_idx  = n_q[JW-1:0];
    jr_idx  = '0;
    unique case (state_q)
      SClear: begin
        mem_we    = 1'b1;
        mem_addr  = clr_q[AW-1:0];
        mem_wdata = '0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == (AW+1)'(TABLE_DEPTH - 1)) state_d = SIdle;
      end
      SIdle: begin
        if (in_valid_i) begin
          state_d = SHash;
          hstep_d = '0;
        end
      end
      SHash: begin
        hstep_d = hstep_q + 1'b1;
        if (hstep_q == 5'd23) begin
          // Murmur tail shift of the last round is folded in here.
          cw_d   = UsedFlag | (hm_q ^ (hm_q >> 16));
          home_d = AW'(hx_q % TABLE_DEPTH);
          slot_d = AW'(hx_q % TABLE_DEPTH);
          cv_d   = req_q.store_value;
          pl_d   = '0;
          have_d = 1'b0;
          n_d    = '0;
          if (cmd_e'(req_q.command) == CmdNone) begin
            rsp_d   = '{status: StAbsent, found_value: '0, slot_index: '0,
                        occupancy: occ_q};
            state_d = SOut;
          end else begin
            state_d = SRead;
          end
        end
      end
      SRead: begin
        state_d = SEval;
      end
      SEval: begin
        n_d = n_q + 1'b1;
        if (cmd_e'(req_q.command) != CmdInsert) begin
          if (rd_q.ctrl == 32'd0) begin
            rsp_d   = '{status: StAbsent, found_value: '0, slot_index: '0,
                        occupancy: occ_q};
            state_d = SOut;
          end else if (c_match) begin
            if (cmd_e'(req_q.command) == CmdErase) begin
              mem_we    = 1'b1;
              mem_wdata = '{ctrl: TombWord, val: rd_q.val, pl: rd_q.pl};
              if (occ_q != '0) occ_d = occ_q - 1'b1;
              rsp_d = '{status: StOk, found_value: '0, slot_index: 10'(slot_q),
                        occupancy: (occ_q != '0) ? occ_q - 1'b1 : occ_q};
            end else begin
              rsp_d = '{status: StOk, found_value: rd_q.val,
                        slot_index: 10'(slot_q), occupancy: occ_q};
            end
            state_d = SOut;
          end else if (n_q == PW'(MAX_PROBE - 1)) begin
            rsp_d   = '{status: StAbsent, found_value: '0, slot_index: '0,
                        occupancy: occ_q};
            state_d = SOut;
          end else begin
            slot_d  = next_slot(slot_q);
            state_d = SRead;
          end
        end else begin
          if (take || swap) begin
            mem_we = 1'b1;
          end
          if (take) begin
            if (!c_used) occ_d = occ_q + 1'b1;
            rsp_d = '{status: StOk, found_value: '0,
                      slot_index: 10'(have_q ? where_q : slot_q),
                      occupancy: c_used ? occ_q : occ_q + 1'b1};
            state_d = SOut;
          end else begin
            if (swap) begin
              cw_d = rd_q.ctrl;
              cv_d = rd_q.val;
              pl_d = rd_q.pl + 1'b1;
              if (!have_q) begin
                have_d  = 1'b1;
                where_d = slot_q;
              end
            end else begin
              pl_d = pl_q + 1'b1;
            end
            if (n_q == PW'(MAX_PROBE - 1)) begin
              state_d = SUndoR;
            end else begin
              slot_d  = next_slot(slot_q);
              state_d = SRead;
            end
          end
        end
      end
      SUndoR: begin
        // Journal entry (n-1) is fetched; n counts entries still to restore.
        if (n_q == '0) begin
          rsp_d   = '{status: StFull, found_value: '0, slot_index: 10'(home_q),
                      occupancy: occ_q};
          state_d = SOut;
        end else begin
          n_d     = n_q - 1'b1;
          jr_idx  = JW'(n_q - 1'b1);
          state_d = SUndoW;
        end
      end
      SUndoW: begin
        mem_we    = 1'b1;
        mem_addr  = jr_slot_q;
        mem_wdata = jr_data_q;
        state_d   = SUndoR;
      end
      SOut: begin
        if (out_ready_i) state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  // Slot memory with a registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_addr] <= mem_wdata;
    rd_q <= mem_q[mem_addr];
  end

  // Journal: every probe is logged, so the entries stay contiguous. A probe
  // that wrote nothing logs an unchanged slot, and restoring it is harmless.
  always_ff @(posedge clk_i) begin
    if (state_q == SEval) begin
      jslot_q[jw_idx] <= slot_q;
      jdata_q[jw_idx] <= rd_q;
    end
    jr_slot_q <= jslot_q[jr_idx];
    jr_data_q <= jdata_q[jr_idx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= SClear;
      clr_q        <= '0;
      grid_scale_q <= CellSizeReset;
      occ_q        <= '0;
      n_q          <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      occ_q   <= occ_d;
      n_q     <= n_d;
      if (cfg_valid_i && cfg_ready_o) grid_scale_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == SIdle && in_valid_i) req_q <= in_data_i;
    hstep_q <= hstep_d;
    hx_q    <= hx_d;
    hm_q    <= hm_d;
    home_q  <= home_d;
    slot_q  <= slot_d;
    where_q <= where_d;
    cw_q    <= cw_d;
    cv_q    <= cv_d;
    pl_q    <= pl_d;
    have_q  <= have_d;
    rsp_q   <= rsp_d;
  end

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == SIdle);
  assign out_valid_o = (state_q == SOut);
  assign out_data_o  = rsp_q;

  `ASSERT_IMPLY(a_occ_range, clk_i, rst_ni, 1'b1, occ_q <= OccW'(TABLE_DEPTH),
                "occupancy exceeds table depth")
  `ASSERT_NEXT(a_undo_full, clk_i, rst_ni,
               state_q == SUndoR && n_q == '0, rsp_q.status == StFull,
               "failed insert must report full")
  `ASSERT_IMPLY(a_no_accept_busy, clk_i, rst_ni, state_q != SIdle, !in_ready_o,
                "input taken while busy")

endmodule
